@@ rtl/hhtm_pkg.sv @@
// hhtm_pkg: shared types and constants of the heading-hold thrust mixer
// used by hhtm_regs, hhtm_ctrl, hhtm_dp and the top level; no dependencies
`default_nettype none

package hhtm_pkg;

  // pulse limits in microseconds
  localparam logic [10:0] THR_MIN    = 11'd1000;
  localparam logic [10:0] THR_MAX    = 11'd2000;
  localparam logic [10:0] THR_IDLE   = 11'd1500;
  localparam logic [10:0] THR_ACTIVE = 11'd1510;

  localparam logic [6:0]  STICK_DZ    = 7'd8;
  localparam logic [31:0] DT_LIMIT_MS = 32'd500;

  // compass wraps once at 360 deg in 1/16 degree
  localparam logic [12:0] COMPASS_TURN = 13'd5760;
  // full turn in 1/1024 degree
  localparam logic [18:0] FULL_TURN    = 19'd368640;

  // floor(x/5) = (x*205) >> 10 for x below 1024
  localparam logic [7:0]  RECIP_5      = 8'd205;
  // step = n / 3125 with n = product*32; floor(2^42/3125)
  localparam logic [30:0] RECIP_3125   = 31'd1407374883;
  localparam logic [11:0] STEP_DIV     = 12'd3125;

  localparam logic [16:0] STEER_LIMIT  = 17'd25600;
  localparam logic signed [9:0] ERR_WRAP = 10'sd180;
  localparam logic signed [9:0] ERR_TURN = 10'sd360;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_MAXDIFF  = 2'd2;
  localparam logic [1:0] REG_TURN     = 2'd3;

  typedef struct packed {
    logic [4:0]  error_deadzone_deg;
    logic [11:0] steer_gain;
    logic [9:0]  max_motor_diff;
    logic [8:0]  turn_rate_deg_s;
  } cfg_t;

  // one strobe per datapath step
  typedef struct packed {
    logic load;
    logic decode;
    logic rate;
    logic mul_dt;
    logic recip;
    logic back;
    logic target;
    logic error;
    logic gain;
    logic result;
  } dp_cmd_t;

  typedef struct packed {
    logic idle_item;
    logic out_stall;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/hhtm_regs.sv @@
// hhtm_regs: APB-style configuration registers of the thrust mixer
// depends on hhtm_pkg for the register layout and indexes
`default_nettype none

module hhtm_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output hhtm_pkg::cfg_t   cfg
);
  import hhtm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_deadzone_deg <= 5'd2;
      cfg.steer_gain         <= 12'd512;
      cfg.max_motor_diff     <= 10'd200;
      cfg.turn_rate_deg_s    <= 9'd30;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_DEADZONE: cfg.error_deadzone_deg <= pwdata[4:0];
        REG_GAIN:     cfg.steer_gain         <= pwdata[11:0];
        REG_MAXDIFF:  cfg.max_motor_diff     <= pwdata[9:0];
        REG_TURN:     cfg.turn_rate_deg_s    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DEADZONE: prdata = {27'd0, cfg.error_deadzone_deg};
      REG_GAIN:     prdata = {20'd0, cfg.steer_gain};
      REG_MAXDIFF:  prdata = {22'd0, cfg.max_motor_diff};
      REG_TURN:     prdata = {23'd0, cfg.turn_rate_deg_s};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/hhtm_dp.sv @@
// hhtm_dp: datapath of the thrust mixer, one step per command strobe
// depends on hhtm_pkg; driven by hhtm_ctrl, holds the output register
`default_nettype none

module hhtm_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hhtm_pkg::cfg_t    cfg,
  input  wire hhtm_pkg::dp_cmd_t cmd,
  output hhtm_pkg::dp_stat_t     stat,
  input  wire logic [11:0]       throttle_pulse,
  input  wire logic [11:0]       steer_pulse,
  input  wire logic [12:0]       compass_heading,
  input  wire logic [31:0]       time_ms,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [10:0]            left_pulse,
  output logic [10:0]            right_pulse,
  output logic [18:0]            target_heading,
  output logic signed [8:0]      heading_error
);
  import hhtm_pkg::*;

  // item registers
  logic [10:0] thr;
  logic [9:0]  steer_off;
  logic [12:0] compass;
  logic [31:0] now_t;
  logic        idle_item;

  // held state
  logic [18:0] held;
  logic        held_valid;
  logic [31:0] prev_time;
  logic        prev_valid;

  // intermediate registers
  logic [8:0]  dt;
  logic [6:0]  mag;
  logic        neg;
  logic        defl_nz;
  logic [15:0] p_rate;
  logic [29:0] num;
  logic [17:0] q0;
  logic [12:0] rem;
  logic signed [8:0]  err;
  logic signed [21:0] s_raw;

  // load
  logic [10:0] thr_c, steer_c;
  logic [12:0] compass_w;
  always_comb begin
    if (throttle_pulse < {1'b0, THR_MIN})      thr_c = THR_MIN;
    else if (throttle_pulse > {1'b0, THR_MAX}) thr_c = THR_MAX;
    else                                       thr_c = throttle_pulse[10:0];
    if (steer_pulse < {1'b0, THR_MIN})         steer_c = THR_MIN;
    else if (steer_pulse > {1'b0, THR_MAX})    steer_c = THR_MAX;
    else                                       steer_c = steer_pulse[10:0];
    compass_w = (compass_heading >= COMPASS_TURN) ? compass_heading - COMPASS_TURN
                                                  : compass_heading;
  end

  // decode
  logic [10:0] steer_sub;
  logic [17:0] q5_prod;
  logic signed [8:0] raw;
  logic [8:0]  raw_mag;
  logic [31:0] time_diff;
  logic [8:0]  dt_w;
  always_comb begin
    steer_sub = steer_c - THR_MIN;
    q5_prod   = 18'(steer_off) * 18'(RECIP_5);
    raw       = $signed({1'b0, q5_prod[17:10]}) - 9'sd100;
    raw_mag   = raw[8] ? 9'(-raw) : 9'(raw);
    time_diff = now_t - prev_time;
    dt_w      = (prev_valid && time_diff <= DT_LIMIT_MS) ? time_diff[8:0] : 9'd0;
  end

  // step scaling: step = mag*rate*dt*1024/100000 = (mag*rate*dt*32)/3125
  logic [24:0] p_dt;
  logic [60:0] q_prod;
  logic [29:0] back_prod;
  logic [29:0] rem_w;
  always_comb begin
    p_dt      = 25'(p_rate) * 25'(dt);
    q_prod    = 61'(num) * 61'(RECIP_3125);
    back_prod = 30'(q0) * 30'(STEP_DIV);
    rem_w     = num - back_prod;
  end

  // target update
  logic [18:0] current;
  logic [18:0] step;
  logic signed [20:0] t_sum;
  logic signed [20:0] t_wrap;
  always_comb begin
    current = {compass, 6'd0};
    step    = 19'(q0) + ((rem >= 13'(STEP_DIV)) ? 19'd1 : 19'd0);
    t_sum   = neg ? $signed({2'b00, held}) - $signed({2'b00, step})
                  : $signed({2'b00, held}) + $signed({2'b00, step});
    if (t_sum < 21'sd0)
      t_wrap = t_sum + $signed({2'b00, FULL_TURN});
    else if (t_sum >= $signed({2'b00, FULL_TURN}))
      t_wrap = t_sum - $signed({2'b00, FULL_TURN});
    else
      t_wrap = t_sum;
  end

  // heading error, truncated toward zero
  logic signed [20:0] diff;
  logic signed [20:0] diff_adj;
  logic signed [20:0] diff_sh;
  logic signed [9:0]  e;
  logic [9:0]         e_mag;
  logic signed [9:0]  e_wrap;
  always_comb begin
    diff     = $signed({2'b00, held}) - $signed({2'b00, current});
    diff_adj = diff[20] ? diff + 21'sd1023 : diff;
    diff_sh  = diff_adj >>> 10;
    e        = diff_sh[9:0];
    e_mag    = e[9] ? 10'(-e) : 10'(e);
    if (e_mag <= {5'd0, cfg.error_deadzone_deg}) e_wrap = 10'sd0;
    else if (e > ERR_WRAP)                       e_wrap = e - ERR_TURN;
    else if (e < -ERR_WRAP)                      e_wrap = e + ERR_TURN;
    else                                         e_wrap = e;
  end

  // gain
  logic signed [21:0] err_x;
  logic signed [21:0] gain_x;
  logic signed [21:0] gain_prod;
  always_comb begin
    err_x     = 22'(err);
    gain_x    = $signed({10'd0, cfg.steer_gain});
    gain_prod = err_x * gain_x;
  end

  // limit, centre and mix
  logic [16:0] half;
  logic [16:0] lim;
  logic signed [21:0] lim_s;
  logic signed [15:0] s_c;
  logic signed [15:0] s_n;
  logic [15:0] s_mag;
  logic [6:0]  m;
  logic [10:0] hi;
  logic [10:0] c;
  logic signed [15:0] s_sh_l, s_sh_r;
  logic signed [12:0] left_w, right_w;
  logic [10:0] left_c, right_c;

  function automatic logic [10:0] clamp_pulse(input logic signed [12:0] v);
    logic [10:0] r;
    if (v < $signed({2'b00, THR_MIN}))      r = THR_MIN;
    else if (v > $signed({2'b00, THR_MAX})) r = THR_MAX;
    else                                    r = v[10:0];
    return r;
  endfunction

  always_comb begin
    half   = {cfg.max_motor_diff, 7'd0};
    lim    = (half < STEER_LIMIT) ? half : STEER_LIMIT;
    lim_s  = $signed({5'd0, lim});
    if (s_raw > lim_s)       s_c = 16'(lim_s);
    else if (s_raw < -lim_s) s_c = 16'(-lim_s);
    else                     s_c = 16'(s_raw);
    s_n     = -s_c;
    s_mag   = s_c[15] ? 16'(s_n) : 16'(s_c);
    m       = s_mag[14:8];
    hi      = THR_MAX - 11'(m);
    c       = (thr > hi) ? hi : thr;
    s_sh_l  = s_c >>> 8;
    s_sh_r  = s_n >>> 8;
    left_w  = $signed({2'b00, c}) + 13'(s_sh_l);
    right_w = $signed({2'b00, c}) + 13'(s_sh_r);
    left_c  = clamp_pulse(left_w);
    right_c = clamp_pulse(right_w);
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      thr       <= thr_c;
      steer_off <= steer_sub[9:0];
      compass   <= compass_w;
      now_t     <= time_ms;
      idle_item <= (thr_c < THR_ACTIVE);
    end
    if (cmd.decode) begin
      dt      <= dt_w;
      mag     <= raw_mag[6:0];
      neg     <= raw[8];
      defl_nz <= (raw_mag[6:0] > STICK_DZ);
    end
    if (cmd.rate)   p_rate <= 16'(mag) * 16'(cfg.turn_rate_deg_s);
    if (cmd.mul_dt) num    <= {p_dt, 5'd0};
    if (cmd.recip)  q0     <= q_prod[59:42];
    if (cmd.back)   rem    <= rem_w[12:0];
    if (cmd.error)  err    <= e_wrap[8:0];
    if (cmd.gain)   s_raw  <= gain_prod;
  end

  // held state
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      held_valid <= 1'b0;
      prev_time  <= '0;
      prev_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        if (idle_item) begin
          held       <= '0;
          held_valid <= 1'b0;
          prev_time  <= '0;
          prev_valid <= 1'b0;
        end else begin
          prev_time  <= now_t;
          prev_valid <= 1'b1;
        end
      end
      if (cmd.target) begin
        if (!held_valid) begin
          held       <= current;
          held_valid <= 1'b1;
        end else if (defl_nz && dt != 9'd0) begin
          held <= t_wrap[18:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      if (idle_item) begin
        left_pulse     <= THR_IDLE;
        right_pulse    <= THR_IDLE;
        target_heading <= '0;
        heading_error  <= '0;
      end else begin
        left_pulse     <= left_c;
        right_pulse    <= right_c;
        target_heading <= held;
        heading_error  <= err;
      end
    end
  end

  assign stat.idle_item = idle_item;
  assign stat.out_stall = out_valid && !out_ready;

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.result |=> out_valid)
    else $error("result written but not shown");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_pulse >= THR_MIN && left_pulse <= THR_MAX &&
                   right_pulse >= THR_MIN && right_pulse <= THR_MAX))
    else $error("motor pulse out of range");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> target_heading < FULL_TURN)
    else $error("target heading not wrapped");

  a_error_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_error <= 9'sd180 && heading_error >= -9'sd180))
    else $error("heading error not wrapped");

endmodule

`default_nettype wire

@@ rtl/hhtm_ctrl.sv @@
// hhtm_ctrl: sequencer of the thrust mixer, one datapath step per state
// depends on hhtm_pkg for the command and status structs
`default_nettype none

module hhtm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output hhtm_pkg::dp_cmd_t       cmd,
  input  wire hhtm_pkg::dp_stat_t stat
);
  import hhtm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RATE   = 4'd2;
  localparam logic [3:0] S_DT     = 4'd3;
  localparam logic [3:0] S_RECIP  = 4'd4;
  localparam logic [3:0] S_BACK   = 4'd5;
  localparam logic [3:0] S_TARGET = 4'd6;
  localparam logic [3:0] S_ERROR  = 4'd7;
  localparam logic [3:0] S_GAIN   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        // idle throttle skips straight to the result
        state_next = stat.idle_item ? S_OUT : S_RATE;
      end
      S_RATE: begin
        cmd.rate   = 1'b1;
        state_next = S_DT;
      end
      S_DT: begin
        cmd.mul_dt = 1'b1;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = S_BACK;
      end
      S_BACK: begin
        cmd.back   = 1'b1;
        state_next = S_TARGET;
      end
      S_TARGET: begin
        cmd.target = 1'b1;
        state_next = S_ERROR;
      end
      S_ERROR: begin
        cmd.error  = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_stall) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> !stat.out_stall)
    else $error("result written over a waiting item");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.result |=> in_ready)
    else $error("sequencer did not return after result");

endmodule

`default_nettype wire

@@ rtl/heading_hold_thrust_mixer_unit.sv @@
// heading_hold_thrust_mixer_unit: top level of the heading-hold thrust mixer
// instantiates hhtm_regs, hhtm_ctrl and hhtm_dp; depends on hhtm_pkg
//
// One item is taken at a time. An active item (throttle at 1510 us or more)
// runs through nine sequencer steps after acceptance before the next item is
// taken; an idle-throttle item skips from stick decode to the result. Steps:
// stick decode, rate and elapsed-time products, a reciprocal multiply with one
// correction for the constant divide, target update, error, gain and the final
// limit and mix. The result sits in an output register; while it is not taken
// the sequencer holds in its last step. The user must write registers over the
// APB-style port only while no item is in work; the block does not enforce it.
`default_nettype none

module heading_hold_thrust_mixer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] throttle_pulse,
  input  wire logic [11:0] steer_pulse,
  input  wire logic [12:0] compass_heading,
  input  wire logic [31:0] time_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      left_pulse,
  output logic [10:0]      right_pulse,
  output logic [18:0]      target_heading,
  output logic signed [8:0] heading_error
);
  import hhtm_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  hhtm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hhtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  hhtm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .throttle_pulse  (throttle_pulse),
    .steer_pulse     (steer_pulse),
    .compass_heading (compass_heading),
    .time_ms         (time_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .left_pulse      (left_pulse),
    .right_pulse     (right_pulse),
    .target_heading  (target_heading),
    .heading_error   (heading_error)
  );

endmodule

`default_nettype wire
